>>> rtl/assert_macros.svh
// assertion macros used by the rtl datapath module cpf_dp
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define AST_SAME(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
        else $error("assertion failed");

// condition implies consequence in the next cycle
`define AST_NEXT(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/cpf_pkg.sv
// cylinder point filter package: widths, config codes and reset values, step codes, control structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cpf_pkg;
    localparam int KEEP_DEPTH = 32;
    localparam int CW    = 21;
    localparam int IW    = 16;
    localparam int KW    = 32;
    localparam int RW    = 16;
    localparam int LIMW  = 7;
    localparam int LLW   = 23;
    localparam int DW    = CW + 1;
    localparam int AW    = 46;
    localparam int NW    = 90;
    localparam int MW    = 34;
    localparam int PW    = 2 * MW;
    localparam int CNTW  = $clog2(KEEP_DEPTH + 1);
    localparam int IDXW  = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;
    localparam int CFGW  = 3;
    localparam int SQ_ITERS  = 22;
    localparam int DIV_ITERS = 32;
    localparam int ITW   = 5;

    localparam logic [CFGW-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFGW-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFGW-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFGW-1:0] CFG_TARGET_X = 3'd3;
    localparam logic [CFGW-1:0] CFG_TARGET_Y = 3'd4;
    localparam logic [CFGW-1:0] CFG_TARGET_Z = 3'd5;
    localparam logic [CFGW-1:0] CFG_RADIUS   = 3'd6;
    localparam logic [CFGW-1:0] CFG_KEEP_LIM = 3'd7;

    localparam logic [RW-1:0]   RADIUS_RST   = 16'd1600;
    localparam logic [LIMW-1:0] KEEP_LIM_RST = 7'd32;

    typedef enum logic [4:0] {
        MS_CX0, MS_CX1, MS_CY0, MS_CY1, MS_CZ0, MS_CZ1,
        MS_DEN0, MS_DEN1, MS_DEN2,
        MS_DA0, MS_DA1, MS_DA2,
        MS_DB0, MS_DB1, MS_DB2,
        MS_NX0, MS_NX1, MS_NX2,
        MS_NY0, MS_NY1, MS_NY2,
        MS_NZ0, MS_NZ1, MS_NZ2,
        MS_R2, MS_REACH
    } t_mstep;

    typedef struct packed {
        logic   load;
        logic   mul_go;
        t_mstep step;
        logic   sqrt_init;
        logic   sqrt_step;
        logic   sqrt_last;
        logic   div_init;
        logic   div_step;
        logic   decide;
        logic   emit;
    } t_cmd;

    typedef struct packed {
        logic set_open;
        logic final_pt;
        logic out_free;
        logic emit_last;
    } t_sts;
endpackage
`default_nettype wire

>>> rtl/cpf_ctrl.sv
// cylinder point filter controller: sequences multiply steps, root, divide,
// insertion and emission; uses cpf_pkg
`timescale 1ns / 1ps
`default_nettype none
module cpf_ctrl
    import cpf_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SQRT, S_REACH, S_DIVI, S_DIV, S_DECIDE, S_EMIT
    } t_state;

    t_state           r_state, n_state;
    t_mstep           r_step, n_step;
    logic [ITW-1:0]   r_it, n_it;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_it    = r_it;
        o_cmd   = '0;
        o_cmd.step = r_step;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step  = MS_CX0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_go = 1'b1;
                if (r_step == MS_R2) begin
                    n_it = '0;
                    if (i_sts.set_open) begin
                        n_state = S_REACH;
                    end else begin
                        o_cmd.sqrt_init = 1'b1;
                        n_state = S_SQRT;
                    end
                end else begin
                    n_step = t_mstep'(r_step + 5'd1);
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_it = r_it + 1'b1;
                if (r_it == ITW'(SQ_ITERS - 1)) begin
                    o_cmd.sqrt_last = 1'b1;
                    n_state = S_REACH;
                end
            end
            S_REACH: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.step   = MS_REACH;
                n_state = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_it = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_it = r_it + 1'b1;
                if (r_it == ITW'(DIV_ITERS - 1)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = i_sts.final_pt ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= MS_CX0;
            r_it    <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_it    <= n_it;
        end
    end
endmodule
`default_nettype wire

>>> rtl/cpf_dp.sv
// cylinder point filter datapath: config registers, shared multiplier,
// root and divide units, sorted store, output register; uses cpf_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cpf_dp
    import cpf_pkg::*;
(
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cfg_we,
    input  wire  [CFGW-1:0] i_cfg_index,
    input  wire  [CW-1:0]   i_cfg_data,
    input  wire  [CW-1:0]   i_px,
    input  wire  [CW-1:0]   i_py,
    input  wire  [CW-1:0]   i_pz,
    input  wire  [IW-1:0]   i_id,
    input  wire             i_final,
    input  t_cmd            i_cmd,
    output t_sts            o_sts,
    input  wire             i_out_ready,
    output logic            o_out_valid,
    output logic [IW-1:0]   o_kept_id,
    output logic [KW-1:0]   o_dist,
    output logic            o_entry_valid,
    output logic            o_run_end
);
    typedef enum logic [3:0] {
        T_CX, T_CY, T_CZ, T_DEN, T_DA, T_DB, T_NUM, T_R2, T_REACH
    } t_tgt;
    typedef enum logic [1:0] {SH0, SH33, SH64} t_sh;

    // configuration
    logic [CW-1:0]   r_ox, r_oy, r_oz, r_tx, r_ty, r_tz;
    logic [RW-1:0]   r_radius;
    logic [LIMW-1:0] r_klim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox <= '0; r_oy <= '0; r_oz <= '0;
            r_tx <= '0; r_ty <= '0; r_tz <= '0;
            r_radius <= RADIUS_RST;
            r_klim   <= KEEP_LIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ORIGIN_X: r_ox <= i_cfg_data;
                CFG_ORIGIN_Y: r_oy <= i_cfg_data;
                CFG_ORIGIN_Z: r_oz <= i_cfg_data;
                CFG_TARGET_X: r_tx <= i_cfg_data;
                CFG_TARGET_Y: r_ty <= i_cfg_data;
                CFG_TARGET_Z: r_tz <= i_cfg_data;
                CFG_RADIUS:   r_radius <= i_cfg_data[RW-1:0];
                CFG_KEEP_LIM: r_klim <= i_cfg_data[LIMW-1:0];
                default: ;
            endcase
        end
    end

    // item differences
    logic [DW-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz, r_dx, r_dy, r_dz;
    logic [IW-1:0] r_id;
    logic          r_final;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax <= {i_px[CW-1], i_px} - {r_ox[CW-1], r_ox};
            r_ay <= {i_py[CW-1], i_py} - {r_oy[CW-1], r_oy};
            r_az <= {i_pz[CW-1], i_pz} - {r_oz[CW-1], r_oz};
            r_bx <= {i_px[CW-1], i_px} - {r_tx[CW-1], r_tx};
            r_by <= {i_py[CW-1], i_py} - {r_ty[CW-1], r_ty};
            r_bz <= {i_pz[CW-1], i_pz} - {r_tz[CW-1], r_tz};
            r_dx <= {r_tx[CW-1], r_tx} - {r_ox[CW-1], r_ox};
            r_dy <= {r_ty[CW-1], r_ty} - {r_oy[CW-1], r_oy};
            r_dz <= {r_tz[CW-1], r_tz} - {r_oz[CW-1], r_oz};
            r_id <= i_id;
            r_final <= i_final;
        end
    end

    // accumulators
    logic [AW-1:0]  r_cx, r_cy, r_cz, r_den, r_da, r_db, r_reach2;
    logic [NW-1:0]  r_num;
    logic [KW-1:0]  r_r2;
    logic [LLW-1:0] r_line;

    function automatic logic [AW-1:0] mag(input logic [AW-1:0] v);
        mag = v[AW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [MW-1:0] sx(input logic [DW-1:0] v);
        sx = {{(MW-DW){v[DW-1]}}, v};
    endfunction

    logic [AW-1:0]  w_mx, w_my, w_mz;
    logic [LLW:0]   w_reach;
    logic [MW-1:0]  w_a, w_b;
    t_tgt           w_tgt;
    t_sh            w_sh;
    logic           w_neg;

    assign w_mx = mag(r_cx);
    assign w_my = mag(r_cy);
    assign w_mz = mag(r_cz);
    assign w_reach = {1'b0, r_line} + {{(LLW+1-RW){1'b0}}, r_radius};

    always_comb begin
        w_a = sx(r_ay); w_b = sx(r_bz); w_tgt = T_CX; w_sh = SH0; w_neg = 1'b0;
        case (i_cmd.step)
            MS_CX0:  begin w_a = sx(r_ay); w_b = sx(r_bz); w_tgt = T_CX; end
            MS_CX1:  begin w_a = sx(r_az); w_b = sx(r_by); w_tgt = T_CX; w_neg = 1'b1; end
            MS_CY0:  begin w_a = sx(r_az); w_b = sx(r_bx); w_tgt = T_CY; end
            MS_CY1:  begin w_a = sx(r_ax); w_b = sx(r_bz); w_tgt = T_CY; w_neg = 1'b1; end
            MS_CZ0:  begin w_a = sx(r_ax); w_b = sx(r_by); w_tgt = T_CZ; end
            MS_CZ1:  begin w_a = sx(r_ay); w_b = sx(r_bx); w_tgt = T_CZ; w_neg = 1'b1; end
            MS_DEN0: begin w_a = sx(r_dx); w_b = sx(r_dx); w_tgt = T_DEN; end
            MS_DEN1: begin w_a = sx(r_dy); w_b = sx(r_dy); w_tgt = T_DEN; end
            MS_DEN2: begin w_a = sx(r_dz); w_b = sx(r_dz); w_tgt = T_DEN; end
            MS_DA0:  begin w_a = sx(r_ax); w_b = sx(r_ax); w_tgt = T_DA; end
            MS_DA1:  begin w_a = sx(r_ay); w_b = sx(r_ay); w_tgt = T_DA; end
            MS_DA2:  begin w_a = sx(r_az); w_b = sx(r_az); w_tgt = T_DA; end
            MS_DB0:  begin w_a = sx(r_bx); w_b = sx(r_bx); w_tgt = T_DB; end
            MS_DB1:  begin w_a = sx(r_by); w_b = sx(r_by); w_tgt = T_DB; end
            MS_DB2:  begin w_a = sx(r_bz); w_b = sx(r_bz); w_tgt = T_DB; end
            MS_NX0:  begin w_a = {2'b0, w_mx[31:0]}; w_b = {2'b0, w_mx[31:0]};
                           w_tgt = T_NUM; end
            MS_NX1:  begin w_a = {2'b0, w_mx[31:0]}; w_b = {20'b0, w_mx[AW-1:32]};
                           w_tgt = T_NUM; w_sh = SH33; end
            MS_NX2:  begin w_a = {20'b0, w_mx[AW-1:32]}; w_b = {20'b0, w_mx[AW-1:32]};
                           w_tgt = T_NUM; w_sh = SH64; end
            MS_NY0:  begin w_a = {2'b0, w_my[31:0]}; w_b = {2'b0, w_my[31:0]};
                           w_tgt = T_NUM; end
            MS_NY1:  begin w_a = {2'b0, w_my[31:0]}; w_b = {20'b0, w_my[AW-1:32]};
                           w_tgt = T_NUM; w_sh = SH33; end
            MS_NY2:  begin w_a = {20'b0, w_my[AW-1:32]}; w_b = {20'b0, w_my[AW-1:32]};
                           w_tgt = T_NUM; w_sh = SH64; end
            MS_NZ0:  begin w_a = {2'b0, w_mz[31:0]}; w_b = {2'b0, w_mz[31:0]};
                           w_tgt = T_NUM; end
            MS_NZ1:  begin w_a = {2'b0, w_mz[31:0]}; w_b = {20'b0, w_mz[AW-1:32]};
                           w_tgt = T_NUM; w_sh = SH33; end
            MS_NZ2:  begin w_a = {20'b0, w_mz[AW-1:32]}; w_b = {20'b0, w_mz[AW-1:32]};
                           w_tgt = T_NUM; w_sh = SH64; end
            MS_R2:   begin w_a = {{(MW-RW){1'b0}}, r_radius};
                           w_b = {{(MW-RW){1'b0}}, r_radius}; w_tgt = T_R2; end
            MS_REACH: begin w_a = {{(MW-LLW-1){1'b0}}, w_reach};
                           w_b = {{(MW-LLW-1){1'b0}}, w_reach}; w_tgt = T_REACH; end
            default: ;
        endcase
    end

    // product register, then accumulate
    logic signed [PW-1:0] r_prod;
    logic                 r_pv;
    t_tgt                 r_ptgt;
    t_sh                  r_psh;
    logic                 r_pneg;
    logic [NW-1:0]        w_ext, w_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul_go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(w_a) * $signed(w_b);
        r_ptgt <= w_tgt;
        r_psh  <= w_sh;
        r_pneg <= w_neg;
    end

    always_comb begin
        w_ext = {{(NW-PW){r_prod[PW-1]}}, r_prod};
        case (r_psh)
            SH33:    w_term = w_ext << 33;
            SH64:    w_term = w_ext << 64;
            default: w_term = w_ext;
        endcase
        if (r_pneg) begin
            w_term = ~w_term + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx <= '0; r_cy <= '0; r_cz <= '0;
            r_den <= '0; r_da <= '0; r_db <= '0;
            r_num <= '0;
        end else if (r_pv) begin
            case (r_ptgt)
                T_CX:    r_cx  <= r_cx  + w_term[AW-1:0];
                T_CY:    r_cy  <= r_cy  + w_term[AW-1:0];
                T_CZ:    r_cz  <= r_cz  + w_term[AW-1:0];
                T_DEN:   r_den <= r_den + w_term[AW-1:0];
                T_DA:    r_da  <= r_da  + w_term[AW-1:0];
                T_DB:    r_db  <= r_db  + w_term[AW-1:0];
                T_NUM:   r_num <= r_num + w_term;
                T_R2:    r_r2  <= w_term[KW-1:0];
                T_REACH: r_reach2 <= w_term[AW-1:0];
                default: ;
            endcase
        end
    end

    // line length: root that takes two bits of the radicand per step
    logic [AW-1:0] r_sq_v, r_sq_res, r_sq_bit;
    logic [AW-1:0] n_sq_v, n_sq_res, w_sq_sum;

    always_comb begin
        w_sq_sum = r_sq_res + r_sq_bit;
        if (r_sq_v >= w_sq_sum) begin
            n_sq_v   = r_sq_v - w_sq_sum;
            n_sq_res = (r_sq_res >> 1) + r_sq_bit;
        end else begin
            n_sq_v   = r_sq_v;
            n_sq_res = r_sq_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
        end else if (i_cmd.sqrt_last) begin
            r_line <= n_sq_res[LLW-1:0];
        end
        if (i_cmd.sqrt_init) begin
            r_sq_v   <= r_den;
            r_sq_res <= '0;
            r_sq_bit <= AW'(1) << (2 * (SQ_ITERS - 1));
        end else if (i_cmd.sqrt_step) begin
            r_sq_v   <= n_sq_v;
            r_sq_res <= n_sq_res;
            r_sq_bit <= r_sq_bit >> 2;
        end
    end

    // key divider: one quotient bit per step
    logic [AW-1:0] r_rem;
    logic [KW-1:0] r_q, r_nlo;
    logic          r_sat;
    logic [AW-1:0] w_shl;
    logic [KW-1:0] w_key;

    assign w_shl = {r_rem[AW-2:0], r_nlo[KW-1]};
    assign w_key = r_sat ? '1 : r_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_sat <= r_num[NW-1:KW] >= {{(NW-KW-AW){1'b0}}, r_den};
            r_rem <= r_num[KW+AW-1:KW];
            r_nlo <= r_num[KW-1:0];
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            r_nlo <= r_nlo << 1;
            if (w_shl >= r_den) begin
                r_rem <= w_shl - r_den;
                r_q   <= {r_q[KW-2:0], 1'b1};
            end else begin
                r_rem <= w_shl;
                r_q   <= {r_q[KW-2:0], 1'b0};
            end
        end
    end

    // sorted store
    logic [KW-1:0]   r_keys [KEEP_DEPTH];
    logic [IW-1:0]   r_ids  [KEEP_DEPTH];
    logic [CNTW-1:0] r_cnt;
    logic            r_open;
    logic [IDXW-1:0] r_eidx;
    logic [LIMW-1:0] w_lim, w_n;
    logic [KEEP_DEPTH-1:0] w_le, w_before, w_ins;
    logic            w_keep, w_ins_any, w_last;

    assign w_lim = (r_klim > LIMW'(KEEP_DEPTH)) ? LIMW'(KEEP_DEPTH) : r_klim;
    assign w_n   = (LIMW'(r_cnt) > w_lim) ? w_lim : LIMW'(r_cnt);
    assign w_keep = (r_den != '0) && (w_key < r_r2) && (r_da < r_reach2)
                    && (r_db < r_reach2);

    always_comb begin
        for (int i = 0; i < KEEP_DEPTH; i++) begin
            w_le[i] = (LIMW'(i) < w_n) && (r_keys[i] <= w_key);
        end
        for (int i = 0; i < KEEP_DEPTH; i++) begin
            w_before[i] = (i == 0) ? 1'b1 : w_le[(i == 0) ? 0 : i - 1];
            w_ins[i] = (LIMW'(i) < w_lim) && w_before[i] && !w_le[i];
        end
        w_ins_any = |w_ins;
    end

    assign w_last = (w_n == '0) || (LIMW'(r_eidx) + 1'b1 == w_n);

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && w_keep && w_ins_any) begin
            for (int i = 0; i < KEEP_DEPTH; i++) begin
                if (LIMW'(i) < w_lim) begin
                    if (!w_before[i]) begin
                        r_keys[i] <= r_keys[(i == 0) ? 0 : i - 1];
                        r_ids[i]  <= r_ids[(i == 0) ? 0 : i - 1];
                    end else if (!w_le[i]) begin
                        r_keys[i] <= w_key;
                        r_ids[i]  <= r_id;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_open <= 1'b0;
            r_eidx <= '0;
        end else if (i_cmd.decide) begin
            r_open <= 1'b1;
            if (w_keep) begin
                if (w_ins_any) begin
                    r_cnt <= (w_n == w_lim) ? w_n[CNTW-1:0] : w_n[CNTW-1:0] + 1'b1;
                end else begin
                    r_cnt <= w_n[CNTW-1:0];
                end
            end
        end else if (i_cmd.emit) begin
            if (w_last) begin
                r_cnt  <= '0;
                r_open <= 1'b0;
                r_eidx <= '0;
            end else begin
                r_eidx <= r_eidx + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            o_kept_id     <= (w_n == '0) ? '0 : r_ids[r_eidx];
            o_dist        <= (w_n == '0) ? '0 : r_keys[r_eidx];
            o_entry_valid <= (w_n != '0);
            o_run_end     <= w_last;
        end
    end

    assign o_sts.set_open  = r_open;
    assign o_sts.final_pt  = r_final;
    assign o_sts.out_free  = !o_out_valid || i_out_ready;
    assign o_sts.emit_last = w_last;

    `AST_SAME(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNTW'(KEEP_DEPTH))
    `AST_SAME(a_emit_free, i_clk, i_rst_n, i_cmd.emit, !o_out_valid || i_out_ready)
    `AST_NEXT(a_last_clear, i_clk, i_rst_n, i_cmd.emit && w_last, r_cnt == '0 && !r_open)
endmodule
`default_nettype wire

>>> rtl/cylinder_point_filter_top_k.sv
// cylinder point filter top level: ports, controller and datapath
// depends on cpf_pkg, cpf_ctrl, cpf_dp
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/tready         tdata x,y,z,id; tlast final point
// m_axis    out  m_axis_tvalid/tready         tdata id,key; tuser valid; tlast end
// cfg       in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// each point passes from accept through the shared multiplier (26 products)
// and the 32-step key divider to the decision; on the first point of a set the
// 22-step line length root runs between the two. the next point is accepted in
// the cycle after the decision, or after the last result of a set enters the
// output register. results leave one per cycle; a stalled m_axis holds emission
// and s_axis_tready low. reset is synchronous active low; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module cylinder_point_filter_top_k
    import cpf_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire  [79:0]      s_axis_tdata,   // point_x, point_y, point_z, system_id
    input  wire              s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire              m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // kept_id, line_dist_sq
    output logic             m_axis_tuser,   // entry_valid
    output logic             m_axis_tlast,
    input  wire              i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire  [CFGW-1:0]  i_cfg_index,
    input  wire  [CW-1:0]    i_cfg_data
);
    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [IW-1:0] w_id;
    logic [KW-1:0] w_dist;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {w_dist, w_id};

    cpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cpf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_px          (s_axis_tdata[20:0]),
        .i_py          (s_axis_tdata[41:21]),
        .i_pz          (s_axis_tdata[62:42]),
        .i_id          (s_axis_tdata[78:63]),
        .i_final       (s_axis_tlast),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_kept_id     (w_id),
        .o_dist        (w_dist),
        .o_entry_valid (m_axis_tuser),
        .o_run_end     (m_axis_tlast)
    );
endmodule
`default_nettype wire
